FILE: rtl/core/plr_pkg.sv
// ----------------------------------------------------------------------------
// Patterned line rasterizer package
// Shared constants and types for the stippled line walker.
// ----------------------------------------------------------------------------
package plr_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int LAYER_COUNT_DEF = 8;

    localparam int STIPPLE_BITS     = 8;
    localparam int COLOR_BITS       = 32;
    localparam int LAYER_BITS       = 3;
    localparam int LAYER_COUNT_BITS = 9;

    // Bits of the input and output words that do not depend on the coordinate width.
    localparam int IN_FIXED_BITS  = STIPPLE_BITS + COLOR_BITS + LAYER_BITS;
    localparam int OUT_FIXED_BITS = COLOR_BITS + LAYER_BITS;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

    typedef struct packed {
        logic x_down;
        logic y_down;
    } dirs_t;

    typedef struct packed {
        logic move_x;
        logic move_y;
        logic done;
    } step_flags_t;

endpackage

FILE: rtl/core/patterned_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Patterned line rasterizer top level
// All-octant Bresenham line walker with an 8-bit rotating stipple pattern.
// ----------------------------------------------------------------------------
// A start word (s_tuser = 0) loads the endpoints, pattern, color and layer and
// produces no output. Each step word (s_tuser = 1) after a start produces one
// pixel, with m_tlast on the endpoint; a step while idle produces nothing. The
// block takes one word per clock unless stalled: every step decision is made
// combinationally from the walker registers, and the pixel waits in one
// output register, so s_tready is high while it is empty or being read.
module patterned_line_rasterizer_top #(
    parameter int COORD_BITS  = plr_pkg::COORD_BITS_DEF,
    parameter int LAYER_COUNT = plr_pkg::LAYER_COUNT_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, end_x, end_y, stipple, pen_color, layer_sel, zero fill
    input  logic [((4*COORD_BITS + plr_pkg::IN_FIXED_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // func
    input  logic s_tuser,

    output logic m_tvalid,
    input  logic m_tready,
    // pix_x, pix_y, pix_color, pix_layer, zero fill
    output logic [((2*COORD_BITS + plr_pkg::OUT_FIXED_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // draw
    output logic m_tuser,
    output logic m_tlast
);

    localparam int CB        = COORD_BITS;
    localparam int OUT_W     = ((2*CB + plr_pkg::OUT_FIXED_BITS + 7) / 8) * 8;
    localparam int OUT_USED  = 2*CB + plr_pkg::OUT_FIXED_BITS;
    localparam int STIP_LSB  = 4*CB;
    localparam int COLOR_LSB = STIP_LSB + plr_pkg::STIPPLE_BITS;
    localparam int LAYER_LSB = COLOR_LSB + plr_pkg::COLOR_BITS;
    localparam logic [plr_pkg::LAYER_COUNT_BITS-1:0] LAYER_LIMIT =
        plr_pkg::LAYER_COUNT_BITS'(LAYER_COUNT);
    localparam logic [plr_pkg::LAYER_COUNT_BITS-1:0] LAYER_MAX =
        plr_pkg::LAYER_COUNT_BITS'(LAYER_COUNT - 1);

    logic                              busy_reg, busy_next;
    logic signed [CB-1:0]              cur_x_reg, cur_x_next;
    logic signed [CB-1:0]              cur_y_reg, cur_y_next;
    logic signed [CB-1:0]              goal_x_reg, goal_x_next;
    logic signed [CB-1:0]              goal_y_reg, goal_y_next;
    logic        [CB:0]                delta_x_reg, delta_x_next;
    logic        [CB:0]                delta_y_reg, delta_y_next;
    logic signed [CB+1:0]              err_reg, err_next;
    plr_pkg::dirs_t                    dirs_reg, dirs_next;
    logic [plr_pkg::STIPPLE_BITS-1:0]  dash_reg, dash_next;
    logic [plr_pkg::COLOR_BITS-1:0]    color_reg, color_next;
    logic [plr_pkg::LAYER_BITS-1:0]    layer_reg, layer_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [CB-1:0]              out_x_reg, out_x_next;
    logic signed [CB-1:0]              out_y_reg, out_y_next;
    logic                              out_draw_reg, out_draw_next;
    logic [plr_pkg::COLOR_BITS-1:0]    out_color_reg, out_color_next;
    logic [plr_pkg::LAYER_BITS-1:0]    out_layer_reg, out_layer_next;
    logic                              out_last_reg, out_last_next;

    logic                              s_accept;
    plr_pkg::func_t                    func;
    logic signed [CB-1:0]              in_x0, in_y0, in_x1, in_y1;
    logic [plr_pkg::STIPPLE_BITS-1:0]  in_stipple;
    logic [plr_pkg::COLOR_BITS-1:0]    in_color;
    logic [plr_pkg::LAYER_BITS-1:0]    in_layer;
    logic signed [CB:0]                diff_x, diff_y;
    logic        [CB:0]                abs_x, abs_y;
    logic signed [CB+1:0]              step_err;
    plr_pkg::step_flags_t              step_flags;
    logic [plr_pkg::STIPPLE_BITS-1:0]  dash_rot;

    plr_step #(
        .COORD_BITS(CB)
    ) u_step (
        .cur_x    (cur_x_reg),
        .cur_y    (cur_y_reg),
        .goal_x   (goal_x_reg),
        .goal_y   (goal_y_reg),
        .delta_x  (delta_x_reg),
        .delta_y  (delta_y_reg),
        .err_acc  (err_reg),
        .err_next (step_err),
        .flags    (step_flags)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        func       = plr_pkg::func_t'(s_tuser);
        in_x0      = signed'(s_tdata[CB-1:0]);
        in_y0      = signed'(s_tdata[2*CB-1:CB]);
        in_x1      = signed'(s_tdata[3*CB-1:2*CB]);
        in_y1      = signed'(s_tdata[4*CB-1:3*CB]);
        in_stipple = s_tdata[STIP_LSB +: plr_pkg::STIPPLE_BITS];
        in_color   = s_tdata[COLOR_LSB +: plr_pkg::COLOR_BITS];
        in_layer   = s_tdata[LAYER_LSB +: plr_pkg::LAYER_BITS];

        diff_x = signed'({in_x1[CB-1], in_x1}) - signed'({in_x0[CB-1], in_x0});
        diff_y = signed'({in_y1[CB-1], in_y1}) - signed'({in_y0[CB-1], in_y0});
        abs_x  = diff_x[CB] ? unsigned'(-diff_x) : unsigned'(diff_x);
        abs_y  = diff_y[CB] ? unsigned'(-diff_y) : unsigned'(diff_y);
        dash_rot = {dash_reg[plr_pkg::STIPPLE_BITS-2:0], dash_reg[plr_pkg::STIPPLE_BITS-1]};

        busy_next    = busy_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        goal_x_next  = goal_x_reg;
        goal_y_next  = goal_y_reg;
        delta_x_next = delta_x_reg;
        delta_y_next = delta_y_reg;
        err_next     = err_reg;
        dirs_next    = dirs_reg;
        dash_next    = dash_reg;
        color_next   = color_reg;
        layer_next   = layer_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_draw_next  = out_draw_reg;
        out_color_next = out_color_reg;
        out_layer_next = out_layer_reg;
        out_last_next  = out_last_reg;

        if (s_accept) begin
            unique case (func)
                plr_pkg::FUNC_START: begin
                    busy_next    = 1'b1;
                    cur_x_next   = in_x0;
                    cur_y_next   = in_y0;
                    goal_x_next  = in_x1;
                    goal_y_next  = in_y1;
                    delta_x_next = abs_x;
                    delta_y_next = abs_y;
                    err_next     = signed'({1'b0, abs_x}) - signed'({1'b0, abs_y});
                    dirs_next.x_down = !(in_x0 < in_x1);
                    dirs_next.y_down = !(in_y0 < in_y1);
                    dash_next    = in_stipple;
                    color_next   = in_color;
                    if ({{(plr_pkg::LAYER_COUNT_BITS - plr_pkg::LAYER_BITS){1'b0}}, in_layer}
                            >= LAYER_LIMIT) begin
                        layer_next = LAYER_MAX[plr_pkg::LAYER_BITS-1:0];
                    end else begin
                        layer_next = in_layer;
                    end
                end
                plr_pkg::FUNC_STEP: begin
                    if (busy_reg) begin
                        dash_next = dash_rot;
                        err_next  = step_err;
                        if (step_flags.move_x) begin
                            cur_x_next = dirs_reg.x_down ? cur_x_reg - CB'(1)
                                                         : cur_x_reg + CB'(1);
                        end
                        if (step_flags.move_y) begin
                            cur_y_next = dirs_reg.y_down ? cur_y_reg - CB'(1)
                                                         : cur_y_reg + CB'(1);
                        end
                        busy_next = !step_flags.done;

                        out_valid_next = 1'b1;
                        out_x_next     = cur_x_reg;
                        out_y_next     = cur_y_reg;
                        out_draw_next  = dash_rot[0];
                        out_color_next = color_reg;
                        out_layer_next = layer_reg;
                        out_last_next  = step_flags.done;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            delta_x_reg   <= '0;
            delta_y_reg   <= '0;
            err_reg       <= '0;
            dirs_reg      <= '0;
            dash_reg      <= '0;
            color_reg     <= '0;
            layer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            delta_x_reg   <= delta_x_next;
            delta_y_reg   <= delta_y_next;
            err_reg       <= err_next;
            dirs_reg      <= dirs_next;
            dash_reg      <= dash_next;
            color_reg     <= color_next;
            layer_reg     <= layer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_draw_reg  <= out_draw_next;
        out_color_reg <= out_color_next;
        out_layer_reg <= out_layer_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_USED){1'b0}}, out_layer_reg, out_color_reg,
                       out_y_reg, out_x_reg};
    assign m_tuser  = out_draw_reg;
    assign m_tlast  = out_last_reg;

    // A start never produces a pixel and always leaves the walker busy.
    a_start_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == plr_pkg::FUNC_START)
            |=> (busy_reg && (m_tvalid == $past(m_tvalid && !m_tready))))
        else $error("start word did not load the walker cleanly");

    // A step while idle leaves the output side untouched.
    a_idle_step_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == plr_pkg::FUNC_STEP && !busy_reg)
            |=> (!busy_reg && (m_tvalid == $past(m_tvalid && !m_tready))))
        else $error("step while idle changed the walker or produced a pixel");

    // A step while busy produces a pixel, and the line ends exactly on the last one.
    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == plr_pkg::FUNC_STEP && busy_reg)
            |=> (m_tvalid && (m_tlast == !busy_reg)))
        else $error("pixel last flag disagrees with walker state");

endmodule

FILE: rtl/core/plr_step.sv
// ----------------------------------------------------------------------------
// Patterned line rasterizer step
// One Bresenham decision: which axes advance, whether the line ends, and the
// updated error term.
// ----------------------------------------------------------------------------
module plr_step #(
    parameter int COORD_BITS = plr_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic signed [COORD_BITS-1:0] goal_x,
    input  logic signed [COORD_BITS-1:0] goal_y,
    input  logic        [COORD_BITS:0]   delta_x,
    input  logic        [COORD_BITS:0]   delta_y,
    input  logic signed [COORD_BITS+1:0] err_acc,
    output logic signed [COORD_BITS+1:0] err_next,
    output plr_pkg::step_flags_t         flags
);

    logic signed [COORD_BITS+2:0] e2;
    logic signed [COORD_BITS+2:0] neg_dy;
    logic signed [COORD_BITS+2:0] dx_wide;
    logic signed [COORD_BITS+1:0] dx_s;
    logic signed [COORD_BITS+1:0] dy_s;
    logic signed [COORD_BITS+1:0] err_mid;
    logic                         x_due;
    logic                         y_due;
    logic                         x_done;
    logic                         y_done;

    always_comb begin
        e2      = {err_acc, 1'b0};
        dx_wide = signed'({2'b00, delta_x});
        neg_dy  = -signed'({2'b00, delta_y});
        dx_s    = signed'({1'b0, delta_x});
        dy_s    = signed'({1'b0, delta_y});

        x_due  = (e2 >= neg_dy);
        x_done = x_due && (cur_x == goal_x);
        flags.move_x = x_due && (cur_x != goal_x);
        err_mid = flags.move_x ? (err_acc - dy_s) : err_acc;

        y_due  = !x_done && (e2 <= dx_wide);
        y_done = y_due && (cur_y == goal_y);
        flags.move_y = y_due && (cur_y != goal_y);
        err_next = flags.move_y ? (err_mid + dx_s) : err_mid;

        flags.done = x_done || y_done;
    end

endmodule
